// ===== rtl/gdl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3D grid density lookup.
// No dependencies; every other file imports this package.
package gdl_pkg;

  localparam int PT_W        = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] OP_QUERY    = 3'd0;
  localparam logic [2:0] OP_WR_LAT   = 3'd1;
  localparam logic [2:0] OP_WR_LON   = 3'd2;
  localparam logic [2:0] OP_WR_ALT   = 3'd3;
  localparam logic [2:0] OP_WR_DENS  = 3'd4;

  localparam logic [1:0] CFG_LAT_POINTS = 2'd0;
  localparam logic [1:0] CFG_LON_POINTS = 2'd1;
  localparam logic [1:0] CFG_ALT_POINTS = 2'd2;
  localparam logic [1:0] CFG_CELL_MODE  = 2'd3;

  typedef enum logic [2:0] {
    K_QUERY   = 3'd0,
    K_WR_LAT  = 3'd1,
    K_WR_LON  = 3'd2,
    K_WR_ALT  = 3'd3,
    K_WR_DENS = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [14:0]        widx;
    logic [31:0]        wval;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [31:0] alt;
  } q_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic idle;
    logic pop_query;
  } bk_stat_t;

  typedef struct packed {
    logic [PT_W-1:0] lat_pts;
    logic [PT_W-1:0] lon_pts;
    logic [PT_W-1:0] alt_pts;
    logic            cell_mode;
  } cfg_t;

endpackage

// ===== rtl/gdl_front.sv =====
`timescale 1ns / 1ps
// Input stage: accepts stream words, decodes the op and drops words that do nothing.
// Depends on gdl_pkg; feeds gdl_queue.
module gdl_front import gdl_pkg::*; #(
  parameter int MAX_AXIS_POINTS = 32,
  parameter int TABLE_DEPTH     = 32768
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [143:0]   in_tdata,   // write_index, write_value, lat, lon, alt, pad
  input  logic [2:0]     in_tuser,   // op
  input  q_stat_t        q_stat,
  output logic           q_push,
  output q_word_t        q_wdata
);

  logic    vld_r, vld_nxt;
  q_word_t word_r, word_nxt;
  logic    keep;
  logic    accept;

  always_comb begin
    word_nxt.widx = in_tdata[14:0];
    word_nxt.wval = in_tdata[46:15];
    word_nxt.lat  = in_tdata[78:47];
    word_nxt.lon  = in_tdata[110:79];
    word_nxt.alt  = in_tdata[142:111];
    word_nxt.kind = K_QUERY;
    keep          = 1'b0;
    case (in_tuser)
      OP_QUERY: begin
        keep = 1'b1;
      end
      OP_WR_LAT: begin
        word_nxt.kind = K_WR_LAT;
        keep = 32'(in_tdata[14:0]) < 32'(MAX_AXIS_POINTS);
      end
      OP_WR_LON: begin
        word_nxt.kind = K_WR_LON;
        keep = 32'(in_tdata[14:0]) < 32'(MAX_AXIS_POINTS);
      end
      OP_WR_ALT: begin
        word_nxt.kind = K_WR_ALT;
        keep = 32'(in_tdata[14:0]) < 32'(MAX_AXIS_POINTS);
      end
      OP_WR_DENS: begin
        word_nxt.kind = K_WR_DENS;
        keep = 32'(in_tdata[14:0]) < 32'(TABLE_DEPTH);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push    = vld_r && !q_stat.full;
  assign in_tready = !vld_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign q_wdata   = word_r;

  always_comb begin
    vld_nxt = vld_r;
    if (q_push) begin
      vld_nxt = 1'b0;
    end
    if (accept && keep) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept && keep) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== rtl/gdl_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of decoded words between the input stage and the lookup engine.
// Depends on gdl_pkg.
module gdl_queue import gdl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_word_t wdata,
  input  logic    pop,
  output q_word_t rdata,
  output q_stat_t stat
);

  q_word_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign rdata      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/gdl_back.sv =====
`timescale 1ns / 1ps
// Lookup engine: breakpoint registers, density memory, cell search, index math
// and the result register. Depends on gdl_pkg; fed by gdl_queue.
module gdl_back import gdl_pkg::*; #(
  parameter int MAX_AXIS_POINTS = 32,
  parameter int TABLE_DEPTH     = 32768
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  q_stat_t       q_stat,
  input  q_word_t       q_rdata,
  output logic          q_pop,
  output bk_stat_t      bk_stat,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata,   // density, cell_index, pad
  output logic          out_tuser    // in_range
);

  localparam int AW   = $clog2(MAX_AXIS_POINTS);
  localparam int CW   = $clog2(MAX_AXIS_POINTS + 1);
  localparam int LW   = 3 * CW;
  localparam int DW   = $clog2(TABLE_DEPTH);
  localparam int CMPW = (LW > DW + 1) ? LW : DW + 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CMP  = 8'b0000_0010,
    ST_SEL  = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_MUL2 = 8'b0001_0000,
    ST_SUM  = 8'b0010_0000,
    ST_READ = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t st_r, st_nxt;

  logic signed [31:0]       bp_r [3][MAX_AXIS_POINTS];
  logic signed [31:0]       pos_r [3];
  logic [MAX_AXIS_POINTS-1:0] ge_r [3];
  logic [MAX_AXIS_POINTS-1:0] le_r [3];
  logic [AW-1:0]            cl_r [3];
  logic [CW-1:0]            stride_r [2];
  logic                     inside_r;
  logic [LW-1:0]            sj_r, ss_r, ssk_r, base_r, idx_r;
  logic                     hit_r;
  logic [31:0]              rd_r;
  logic [31:0]              mem_r [TABLE_DEPTH];

  logic [31:0]              dens_r;
  logic [14:0]              cidx_r;
  logic                     rng_r;
  logic                     ovld_r, ovld_nxt;

  logic [CW-1:0]            n_cl [3];
  logic [CW-1:0]            top  [3];
  logic [CW-1:0]            nm1  [3];
  logic [CW-1:0]            sel  [3];
  logic [AW-1:0]            cl_nxt [3];
  logic                     in_ax [3];
  logic [PT_W-1:0]          pts  [3];
  logic                     out_free;
  logic                     mem_we;
  logic [DW-1:0]            mem_addr;

  assign pts[0] = cfg.lat_pts;
  assign pts[1] = cfg.lon_pts;
  assign pts[2] = cfg.alt_pts;

  assign q_pop    = (st_r == ST_IDLE) && !q_stat.empty;
  assign out_free = !ovld_r || out_tready;
  assign mem_we   = q_pop && (q_rdata.kind == K_WR_DENS);
  assign mem_addr = (st_r == ST_IDLE) ? DW'(q_rdata.widx) : DW'(idx_r);

  assign bk_stat.idle      = st_r == ST_IDLE;
  assign bk_stat.pop_query = q_pop && (q_rdata.kind == K_QUERY);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (pts[a] < PT_W'(2)) begin
        n_cl[a] = CW'(2);
      end else if (32'(pts[a]) > 32'(MAX_AXIS_POINTS)) begin
        n_cl[a] = CW'(MAX_AXIS_POINTS);
      end else begin
        n_cl[a] = CW'(pts[a]);
      end
      nm1[a] = n_cl[a] - CW'(1);
      top[a] = cfg.cell_mode ? n_cl[a] - CW'(2) : nm1[a];
      in_ax[a] = ge_r[a][0] && le_r[a][nm1[a][AW-1:0]];
      sel[a] = nm1[a];
      for (int e = MAX_AXIS_POINTS - 2; e >= 0; e--) begin
        if (ge_r[a][e] && le_r[a][e+1] && (32'(e + 1) < 32'(n_cl[a]))) begin
          sel[a] = CW'(e);
        end
      end
      cl_nxt[a] = AW'((sel[a] > top[a]) ? top[a] : sel[a]);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    ovld_nxt = ovld_r;
    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (q_pop && (q_rdata.kind == K_QUERY)) begin
          st_nxt = ST_CMP;
        end
      end
      ST_CMP:  st_nxt = ST_SEL;
      ST_SEL:  st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_MUL2;
      ST_MUL2: st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_READ;
      ST_READ: st_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // breakpoint writes and query capture
  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_rdata.kind)
        K_WR_LAT: bp_r[0][q_rdata.widx[AW-1:0]] <= q_rdata.wval;
        K_WR_LON: bp_r[1][q_rdata.widx[AW-1:0]] <= q_rdata.wval;
        K_WR_ALT: bp_r[2][q_rdata.widx[AW-1:0]] <= q_rdata.wval;
        K_QUERY: begin
          pos_r[0] <= q_rdata.lat;
          pos_r[1] <= q_rdata.lon;
          pos_r[2] <= q_rdata.alt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CMP) begin
      for (int a = 0; a < 3; a++) begin
        for (int e = 0; e < MAX_AXIS_POINTS; e++) begin
          ge_r[a][e] <= pos_r[a] >= bp_r[a][e];
          le_r[a][e] <= pos_r[a] <= bp_r[a][e];
        end
      end
    end
    if (st_r == ST_SEL) begin
      for (int a = 0; a < 3; a++) begin
        cl_r[a] <= cl_nxt[a];
      end
      stride_r[0] <= cfg.cell_mode ? nm1[0] : n_cl[0];
      stride_r[1] <= cfg.cell_mode ? nm1[1] : n_cl[1];
      inside_r    <= in_ax[0] && in_ax[1] && in_ax[2];
    end
    if (st_r == ST_MUL) begin
      sj_r <= LW'(stride_r[0]) * LW'(cl_r[1]);
      ss_r <= LW'(stride_r[0]) * LW'(stride_r[1]);
    end
    if (st_r == ST_MUL2) begin
      ssk_r  <= ss_r * LW'(cl_r[2]);
      base_r <= LW'(cl_r[0]) + sj_r;
    end
    if (st_r == ST_SUM) begin
      idx_r <= base_r + ssk_r;
    end
    if (st_r == ST_READ) begin
      hit_r <= CMPW'(idx_r) < CMPW'(TABLE_DEPTH);
    end
    if ((st_r == ST_DONE) && out_free) begin
      rng_r  <= inside_r;
      dens_r <= (inside_r && hit_r) ? rd_r : 32'd0;
      cidx_r <= inside_r ? 15'(idx_r) : 15'd0;
    end
  end

  // single-port density memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= q_rdata.wval;
    end
    rd_r <= mem_r[mem_addr];
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {1'b0, cidx_r, dens_r};
  assign out_tuser  = rng_r;

endmodule

// ===== rtl/grid_density_lookup_3d.sv =====
`timescale 1ns / 1ps
// 3D rectilinear grid density lookup: top level with configuration registers.
// Depends on gdl_pkg, gdl_front, gdl_queue and gdl_back.
//
// Words on the input stream either load a breakpoint (latitude, longitude or
// altitude, up to MAX_AXIS_POINTS per axis), load a density word (TABLE_DEPTH
// entries), or query a position; only queries return a word. Words with an
// unused op or an out-of-range table index are dropped on entry. The input
// stage buffers one word and a four-word queue decouples it from the lookup
// engine, so the input can still accept while a result waits on the output.
// The engine handles one word at a time: a table load needs only its pop, a
// query 8 steps (pop, parallel compare, cell select, two multiply steps, index
// add, density memory read, result load), plus any output stall. Those 8 steps
// of the engine's sequencer and its single-port density memory set the rate.
// Tables have no reset value; querying a cell or breakpoint never written
// gives an unspecified density. Write configuration only while idle.
module grid_density_lookup_3d import gdl_pkg::*; #(
  parameter int MAX_AXIS_POINTS = 32,
  parameter int TABLE_DEPTH     = 32768
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,   // write_index, write_value, lat, lon, alt, pad
  input  logic [2:0]    in_tuser,   // op
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata,  // density, cell_index, pad
  output logic          out_tuser,  // in_range
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [5:0]    cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  q_stat_t  q_stat;
  q_word_t  q_wdata, q_rdata;
  logic     q_push, q_pop;
  bk_stat_t bk_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_LAT_POINTS: cfg_nxt.lat_pts   = cfg_wdata;
        CFG_LON_POINTS: cfg_nxt.lon_pts   = cfg_wdata;
        CFG_ALT_POINTS: cfg_nxt.alt_pts   = cfg_wdata;
        CFG_CELL_MODE:  cfg_nxt.cell_mode = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lat_pts   <= PT_W'(2);
      cfg_r.lon_pts   <= PT_W'(2);
      cfg_r.alt_pts   <= PT_W'(2);
      cfg_r.cell_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gdl_front #(
    .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
    .TABLE_DEPTH     (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  gdl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  gdl_back #(
    .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
    .TABLE_DEPTH     (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .bk_stat    (bk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop_query |=> !bk_stat.idle)
    else $error("engine idle right after taking a query");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 48'd0))
    else $error("nonzero result for position outside the grid");
`endif

endmodule
